@@ hw/rtl/hsl_pkg.sv @@
// ----------------------------------------------------------------------------
// hsl_pkg: shared types and constants for the HSL to RGB converter
// Fixed-point widths, hue ramp breakpoints and the reciprocal constants
// used for the final divide.
// ----------------------------------------------------------------------------
package hsl_pkg;

  typedef logic        [8:0]  hue_t;   // degrees, 0..511 on input
  typedef logic        [6:0]  pct_t;   // percent, 0..127 on input
  typedef logic        [7:0]  byte_t;  // alpha and channel bytes
  typedef logic signed [15:0] pq_t;    // p, q and q-p in units of 1/10000
  typedef logic signed [21:0] v60_t;   // ramp value in units of 1/600000
  typedef logic signed [25:0] scl_t;   // 17 * v60
  typedef logic        [23:0] num_t;   // positive, unsaturated numerator
  typedef logic        [5:0]  ramp_t;  // ramp position 0..60

  localparam int unsigned HueWrap   = 360;
  localparam int unsigned OffRed    = 120;
  localparam int unsigned OffGreen  = 0;
  localparam int unsigned OffBlue   = 240;
  localparam int unsigned RampRise  = 60;
  localparam int unsigned RampFlat  = 180;
  localparam int unsigned RampFall  = 240;
  localparam int unsigned RampSteps = 60;
  localparam int unsigned LightHalf = 50;
  localparam int unsigned PctScale  = 100;

  // 255 / 600000 reduces to 17 / 40000
  localparam int unsigned YScale    = 17;
  localparam int unsigned DivDen    = 40000;
  localparam int unsigned SatLimit  = 256 * DivDen;

  // floor(y / DivDen) = (y * DivMul) >> DivShift, exact for 24-bit y
  localparam int unsigned NumW      = 24;
  localparam int unsigned MulW      = 25;
  localparam int unsigned DivShift  = 40;
  localparam logic [MulW-1:0] DivMul =
    MulW'(((64'd1 << DivShift) + 64'(DivDen) - 64'd1) / 64'(DivDen));

  // register stages from input to result ports
  localparam int unsigned PipeDepth = 5;

endpackage

@@ hw/rtl/hsl_chan.sv @@
// ----------------------------------------------------------------------------
// hsl_chan: one color channel of the HSL to RGB converter
// Four register stages: hue ramp select, ramp multiply-add, scale and clamp,
// reciprocal divide by 40000.
// ----------------------------------------------------------------------------
module hsl_chan import hsl_pkg::*; (
  input  logic  clk_i,
  input  hue_t  hue_i,     // wrapped hue, 0..359
  input  hue_t  offset_i,  // channel angle offset
  input  pq_t   p_i,
  input  pq_t   q_i,
  output byte_t chan_o
);

  // stage A: channel angle and ramp segment
  logic [9:0] ang_sum;
  hue_t       ang;
  v60_t       base_d, base_q;
  pq_t        diff_d, diff_q;
  ramp_t      pos_d, pos_q;

  always_comb begin
    ang_sum = {1'b0, hue_i} + {1'b0, offset_i};
    ang     = (ang_sum >= 10'(HueWrap)) ? 9'(ang_sum - 10'(HueWrap)) : ang_sum[8:0];
    diff_d  = q_i - p_i;
    if (ang < 9'(RampRise)) begin
      base_d = v60_t'(p_i) * v60_t'(RampSteps);
      pos_d  = ang[5:0];
    end else if (ang < 9'(RampFlat)) begin
      base_d = v60_t'(q_i) * v60_t'(RampSteps);
      pos_d  = '0;
    end else if (ang < 9'(RampFall)) begin
      base_d = v60_t'(p_i) * v60_t'(RampSteps);
      pos_d  = 6'(9'(RampFall) - ang);
    end else begin
      base_d = v60_t'(p_i) * v60_t'(RampSteps);
      pos_d  = '0;
    end
  end

  // stage B: 60p + (q-p)*t, or 60q on the flat segment
  v60_t v60_d, v60_q;
  assign v60_d = base_q + v60_t'(diff_q) * v60_t'(pos_q);

  // stage C: scale by 17, clamp below zero and at the top
  scl_t y_full;
  num_t num_d, num_q;
  logic sat_d, sat_q;

  always_comb begin
    y_full = scl_t'(v60_q) * scl_t'(YScale);
    sat_d  = (y_full >= scl_t'(SatLimit));
    num_d  = (y_full <= scl_t'(0)) ? '0 : y_full[NumW-1:0];
  end

  // stage D: quotient by reciprocal multiply
  logic [NumW+MulW-1:0] prod;
  byte_t                chan_d, chan_q;

  always_comb begin
    prod   = (NumW+MulW)'(num_q) * (NumW+MulW)'(DivMul);
    chan_d = sat_q ? 8'hFF : prod[DivShift +: 8];
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    diff_q <= diff_d;
    pos_q  <= pos_d;
    v60_q  <= v60_d;
    num_q  <= num_d;
    sat_q  <= sat_d;
    chan_q <= chan_d;
  end

  assign chan_o = chan_q;

endmodule

@@ hw/rtl/hsl_to_rgb_converter_unit.sv @@
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_unit: HSL plus alpha to 8-bit RGB plus alpha
// A transaction taken on start_i passes through five register stages and
// shows on the result ports with done_o high.
// Throughput: one transaction per clock; busy_o is never raised and the
// receiver cannot stall, so the five-stage pipeline always advances.
// Reset: rst_ni (async, active low) clears the stage valid bits only; data
// registers are not reset.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_unit import hsl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  input  hue_t  hue_i,
  input  pct_t  saturation_i,
  input  pct_t  lightness_i,
  input  byte_t alpha_in_i,
  output logic  done_o,
  output byte_t red_o,
  output byte_t green_o,
  output byte_t blue_o,
  output byte_t alpha_out_o
);

  // Pipeline never blocks: every start is a transaction.
  assign busy_o = 1'b0;

  logic take;
  assign take = start_i & ~busy_o;

  // --------------------------------------------------------------------------
  // Stage 1: wrap hue into 0..359, form q and p in units of 1/10000.
  //   light < 50 : q = 100l + ls
  //   otherwise  : q = 100l + 100s - ls
  //   p = 200l - q
  // Out-of-range percent inputs follow the same formulas; the channel clamp
  // handles the results. p lands in -1350..16129, q in 0..12700.
  // --------------------------------------------------------------------------
  logic [13:0] ls_prod;
  logic [15:0] l100, s100, l200;
  hue_t        hue_d, hue_q;
  pq_t         q_d, q_q;
  pq_t         p_d, p_q;

  always_comb begin
    ls_prod = 14'(lightness_i) * 14'(saturation_i);
    l100    = 16'(lightness_i) * 16'(PctScale);
    s100    = 16'(saturation_i) * 16'(PctScale);
    l200    = {l100[14:0], 1'b0};
    hue_d   = (hue_i >= 9'(HueWrap)) ? 9'(hue_i - 9'(HueWrap)) : hue_i;
    if (lightness_i < 7'(LightHalf)) begin
      q_d = pq_t'(l100) + pq_t'(ls_prod);
    end else begin
      q_d = pq_t'(l100) + pq_t'(s100) - pq_t'(ls_prod);
    end
    p_d = pq_t'(l200) - q_d;
  end

  always_ff @(posedge clk_i) begin
    hue_q <= hue_d;
    q_q   <= q_d;
    p_q   <= p_d;
  end

  // --------------------------------------------------------------------------
  // Stages 2..5: one ramp/scale/divide pipe per channel.
  // Red at +120 degrees, green at 0, blue at +240 (same as -120).
  // --------------------------------------------------------------------------
  hsl_chan u_chan_red (
    .clk_i    (clk_i),
    .hue_i    (hue_q),
    .offset_i (9'(OffRed)),
    .p_i      (p_q),
    .q_i      (q_q),
    .chan_o   (red_o)
  );

  hsl_chan u_chan_green (
    .clk_i    (clk_i),
    .hue_i    (hue_q),
    .offset_i (9'(OffGreen)),
    .p_i      (p_q),
    .q_i      (q_q),
    .chan_o   (green_o)
  );

  hsl_chan u_chan_blue (
    .clk_i    (clk_i),
    .hue_i    (hue_q),
    .offset_i (9'(OffBlue)),
    .p_i      (p_q),
    .q_i      (q_q),
    .chan_o   (blue_o)
  );

  // --------------------------------------------------------------------------
  // Valid bits and alpha travel alongside the channel data.
  // --------------------------------------------------------------------------
  logic [PipeDepth-1:0] vld_d, vld_q;
  byte_t                alpha_d [PipeDepth];
  byte_t                alpha_q [PipeDepth];

  always_comb begin
    vld_d      = {vld_q[PipeDepth-2:0], take};
    alpha_d[0] = alpha_in_i;
    for (int i = 1; i < PipeDepth; i++) begin
      alpha_d[i] = alpha_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PipeDepth; i++) begin
      alpha_q[i] <= alpha_d[i];
    end
  end

  assign done_o      = vld_q[PipeDepth-1];
  assign alpha_out_o = alpha_q[PipeDepth-1];

endmodule

@@ dv/hsl_to_rgb_converter_unit_checker.sv @@
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_unit_checker: result checker for the HSL converter
// Watches the command and result channels, computes the expected pixel for
// each accepted transaction and compares every result field in order.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_unit_checker import hsl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  busy_i,
  input  hue_t  hue_i,
  input  pct_t  saturation_i,
  input  pct_t  lightness_i,
  input  byte_t alpha_in_i,
  input  logic  done_i,
  input  byte_t red_i,
  input  byte_t green_i,
  input  byte_t blue_i,
  input  byte_t alpha_out_i,
  output int    fail_count_o,
  output int    outstanding_o,
  output int    checked_o
);

  typedef struct packed {
    byte_t red;
    byte_t green;
    byte_t blue;
    byte_t alpha;
  } rgba_t;

  // signed copies so all ramp arithmetic stays in longint
  localparam longint ChanMax = 255;
  localparam longint RampDen = 600000;  // 60 steps x 10000
  localparam longint Pct     = PctScale;
  localparam longint Half    = LightHalf;
  localparam longint Steps   = RampSteps;

  rgba_t pixel_q[$];
  int    errors  = 0;
  int    checked = 0;

  // one channel: hue ramp at angle deg, scaled by 255/600000, clamped
  function automatic byte_t ramp_to_byte(longint p, longint q, int unsigned deg);
    longint v60;
    longint num;
    if (deg < RampRise) begin
      v60 = Steps * p + (q - p) * longint'(deg);
    end else if (deg < RampFlat) begin
      v60 = Steps * q;
    end else if (deg < RampFall) begin
      v60 = Steps * p + (q - p) * longint'(RampFall - deg);
    end else begin
      v60 = Steps * p;
    end
    num = v60 * ChanMax;
    if (num <= 0) return '0;
    num = num / RampDen;
    if (num > ChanMax) num = ChanMax;
    return byte_t'(num);
  endfunction

  function automatic rgba_t hsl_to_rgba(hue_t hue, pct_t sat, pct_t lit, byte_t alpha);
    int unsigned deg;
    longint      s;
    longint      l;
    longint      q;
    longint      p;
    rgba_t       px;
    deg = int'(hue) % HueWrap;
    s   = longint'(sat);
    l   = longint'(lit);
    if (l < Half) q = l * (Pct + s);
    else          q = Pct * l + Pct * s - l * s;
    p = 2 * Pct * l - q;
    px.red   = ramp_to_byte(p, q, (deg + OffRed) % HueWrap);
    px.green = ramp_to_byte(p, q, (deg + OffGreen) % HueWrap);
    px.blue  = ramp_to_byte(p, q, (deg + OffBlue) % HueWrap);
    px.alpha = alpha;
    return px;
  endfunction

  always @(posedge clk_i) begin
    rgba_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (pixel_q.size() == 0) begin
          $error("done_o with no transaction outstanding");
          errors++;
        end else begin
          want = pixel_q.pop_front();
          checked++;
          if (red_i !== want.red) begin
            $error("red_o: expected %0d, actual %0d", want.red, red_i);
            errors++;
          end
          if (green_i !== want.green) begin
            $error("green_o: expected %0d, actual %0d", want.green, green_i);
            errors++;
          end
          if (blue_i !== want.blue) begin
            $error("blue_o: expected %0d, actual %0d", want.blue, blue_i);
            errors++;
          end
          if (alpha_out_i !== want.alpha) begin
            $error("alpha_out_o: expected %0d, actual %0d", want.alpha, alpha_out_i);
            errors++;
          end
        end
      end
      if (start_i && !busy_i) begin
        pixel_q = {pixel_q, hsl_to_rgba(hue_i, saturation_i, lightness_i, alpha_in_i)};
      end
    end
    fail_count_o  <= errors;
    outstanding_o <= pixel_q.size();
    checked_o     <= checked;
  end

endmodule

@@ dv/hsl_to_rgb_converter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_unit_tb: top-level testbench for the HSL converter
// Drives a directed set of hue breakpoints, grey, black, white and
// out-of-range inputs, then random pixels in bursts; the checker module
// predicts and compares every result.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_unit_tb import hsl_pkg::*; ();

  localparam int NumRandom     = 700;
  localparam int NumDirected   = 23;
  localparam int WatchdogLimit = 200;   // cycles with no transaction at all

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start_i = 1'b0;
  logic  busy_o;
  hue_t  hue_i = '0;
  pct_t  saturation_i = '0;
  pct_t  lightness_i = '0;
  byte_t alpha_in_i = '0;
  logic  done_o;
  byte_t red_o;
  byte_t green_o;
  byte_t blue_o;
  byte_t alpha_out_o;

  int fail_count;
  int outstanding;
  int checked;

  int idle_cycles = 0;
  int burst_left  = 0;
  int n_sent      = 0;
  int n_wild      = 0;   // hue above 359 or saturation/lightness above 100
  int n_grey      = 0;

  hsl_to_rgb_converter_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .alpha_in_i   (alpha_in_i),
    .done_o       (done_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_out_o  (alpha_out_o)
  );

  hsl_to_rgb_converter_unit_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .hue_i         (hue_i),
    .saturation_i  (saturation_i),
    .lightness_i   (lightness_i),
    .alpha_in_i    (alpha_in_i),
    .done_i        (done_o),
    .red_i         (red_o),
    .green_i       (green_o),
    .blue_i        (blue_o),
    .alpha_out_i   (alpha_out_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  always #5 clk_i = ~clk_i;

  // Any accepted command or any result strobe counts as progress.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else                                idle_cycles <= idle_cycles + 1;
  end

  // Watchdog: a stuck handshake or a dead pipeline ends the run here.
  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("Watchdog: no transaction for %0d cycles", WatchdogLimit);
    $display("Test completed with failures");
    $finish;
  end

  // Present one pixel and return at the edge that accepts it. start_i stays
  // high on return so back-to-back transactions need no extra assignment.
  task automatic send_pixel(hue_t h, pct_t s, pct_t l, byte_t a);
    start_i      <= 1'b1;
    hue_i        <= h;
    saturation_i <= s;
    lightness_i  <= l;
    alpha_in_i   <= a;
    do @(posedge clk_i); while (busy_o);
    n_sent++;
    if (h > 359 || s > 100 || l > 100) n_wild++;
    if (s == 0) n_grey++;
  endtask

  // Sender pacing: bursts of random length, random gaps in between. About a
  // quarter of the bursts are long so there are stretches with no idling.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 7);
    end
  endtask

  // Stop sending until every outstanding pixel has come back. The checker
  // publishes its count through a register, hence the first edge before polling.
  task automatic wait_for_drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    hue_t  dir_hue   [NumDirected];
    pct_t  dir_sat   [NumDirected];
    pct_t  dir_lit   [NumDirected];
    byte_t dir_alpha [NumDirected];
    hue_t  h;
    pct_t  s;
    pct_t  l;
    int    kind;

    // Directed set: every ramp breakpoint on the green channel (red and blue
    // follow at +120/+240), grey, black and white, both lightness branches,
    // hue wrap above 359 and saturation/lightness above 100 (clamping).
    dir_hue   = '{  0,  59,  60, 119, 120, 179, 180, 239,
                  240, 299, 300, 359, 200,  45,  90, 150,
                   30, 210, 360, 511, 100, 270, 330};
    dir_sat   = '{100, 100, 100, 100, 100, 100, 100, 100,
                  100, 100, 100, 100,   0,   0, 100, 100,
                   60,  60,  80, 100, 127,  90, 127};
    dir_lit   = '{ 50,  50,  50,  50,  50,  50,  50,  50,
                   50,  50,  50,  50,  37, 100,   0, 100,
                   49,  50,  40,  50,  30, 127, 127};
    dir_alpha = '{255,   0, 170,  85, 255,   1, 128, 254,
                   64, 200,  15, 240,  99,   0, 255,  33,
                   77, 177,  11, 222,   3, 240, 127};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send_pixel(dir_hue[i], dir_sat[i], dir_lit[i], dir_alpha[i]);
      pace_sender();
    end
    wait_for_drain();

    // Random part: mostly legal colors, some hue wrap, some full-width noise
    // so every input bit toggles.
    for (int i = 0; i < NumRandom; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        h = hue_t'($urandom_range(0, 359));
        s = (kind == 0) ? '0 : pct_t'($urandom_range(0, 100));
        l = pct_t'($urandom_range(0, 100));
      end else if (kind == 7) begin
        h = hue_t'($urandom_range(360, 511));
        s = pct_t'($urandom_range(0, 100));
        l = pct_t'($urandom_range(0, 100));
      end else begin
        h = hue_t'($urandom_range(0, 511));
        s = pct_t'($urandom_range(0, 127));
        l = pct_t'($urandom_range(0, 127));
      end
      send_pixel(h, s, l, byte_t'($urandom_range(0, 255)));
      if (i == NumRandom / 2) wait_for_drain();
      else                    pace_sender();
    end

    // Let the pipeline empty, then keep clocking to catch stray strobes.
    wait_for_drain();
    repeat (PipeDepth + 3) @(posedge clk_i);

    if (outstanding != 0) $error("%0d pixels never returned", outstanding);

    $display("Sent %0d pixels (%0d directed), %0d results checked", n_sent,
             NumDirected, checked);
    $display("Including %0d out-of-range inputs and %0d zero-saturation greys",
             n_wild, n_grey);

    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ hsl_to_rgb_converter_unit.f @@
hw/rtl/hsl_pkg.sv
hw/rtl/hsl_chan.sv
hw/rtl/hsl_to_rgb_converter_unit.sv
dv/hsl_to_rgb_converter_unit_checker.sv
dv/hsl_to_rgb_converter_unit_tb.sv
